/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define FPCE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define FPCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/fpce_pkg.sv */
package fpce_pkg;

  localparam int DEPTH_DEF    = 1024;
  localparam int SUM_BITS_DEF = 32;

  localparam int IDX_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  // register index taken from the word address
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic q_step;
    logic a_step;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic q_done;
    logic a_done;
  } sts_t;

endpackage

/* src/fenwick_prefix_count_engine.sv */
// Binary indexed tree of DEPTH partial sums, SUM_BITS wide, wrapping. cmd 0 adds delta at
// index, cmd 1 returns the sum of entries 1..index, cmd 2 returns the sum of entries
// 1..index-1 and then adds one at index; cmd 3 is dropped. Query indices are clamped to
// size_in_use (register 0, at byte address 0), capped at DEPTH. One transaction is worked
// at a time: the tree walk visits one node per cycle through the one-read, one-write sum
// memory; a query sums and an add updates at most log2(DEPTH)+1 nodes, and for
// count-and-insert at DEPTH 1024 the nodes summed and updated never exceed 11 together.
// After reset the sum memory is cleared one address at a time, and no transaction is
// taken until that is done. A finished result waits in an output register while the next
// transaction is already being worked; a query that ends while that register is still
// full holds until the waiting result is taken.
`include "assert_macros.svh"

module fenwick_prefix_count_engine #(
  parameter int DEPTH    = fpce_pkg::DEPTH_DEF,
  parameter int SUM_BITS = fpce_pkg::SUM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic [fpce_pkg::IDX_W-1:0]         index,
  input  logic signed [fpce_pkg::DATA_W-1:0] delta,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fpce_pkg::DATA_W-1:0] prefix_sum,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fpce_pkg::ADDR_W-1:0]        paddr,
  input  logic [fpce_pkg::DATA_W-1:0]        pwdata,
  output logic [fpce_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [fpce_pkg::IDX_W-1:0] size_in_use;
  fpce_pkg::ctl_t ctl;
  fpce_pkg::sts_t sts;
  logic size_sel;

  assign pready   = 1'b1;
  assign size_sel = (paddr[2] == fpce_pkg::REG_SIZE_IN_USE);
  assign prdata   = size_sel ? fpce_pkg::DATA_W'(size_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= fpce_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && pready && size_sel) begin
      size_in_use <= pwdata[fpce_pkg::IDX_W-1:0];
    end
  end

  fpce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fpce_datapath #(
    .DEPTH    (DEPTH),
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .index       (index),
    .delta       (delta),
    .size_in_use (size_in_use),
    .ctl         (ctl),
    .sts         (sts),
    .prefix_sum  (prefix_sum)
  );

  `FPCE_ASSERT_ALWAYS(a_clear_blocks_input, clk, rst |=> !in_ready, "input taken during clear pass")
  `FPCE_ASSERT(a_one_at_a_time, clk, rst, (in_valid && in_ready && cmd != fpce_pkg::CMD_NONE) |=> !in_ready, "second transaction taken while busy")
  `FPCE_ASSERT(a_no_result_for_add, clk, rst, (in_valid && in_ready && (cmd == fpce_pkg::CMD_ADD || cmd == fpce_pkg::CMD_NONE)) |=> !$rose(out_valid), "result raised by a command without one")

endmodule

/* src/fpce_ctrl.sv */
module fpce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpce_pkg::sts_t    sts,
  output fpce_pkg::ctl_t    ctl
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_QUERY = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t state, state_next;
  fpce_pkg::cmd_t cmd_q;

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          unique case (fpce_pkg::cmd_t'(cmd))
            fpce_pkg::CMD_QUERY, fpce_pkg::CMD_COUNT: state_next = ST_QUERY;
            fpce_pkg::CMD_ADD:                        state_next = ST_ADD;
            default:                                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_QUERY: begin
        ctl.q_step = 1'b1;
        // result register must be free or emptying this cycle
        if (sts.q_done && (!out_valid || out_ready)) begin
          ctl.out_load = 1'b1;
          state_next = (cmd_q == fpce_pkg::CMD_COUNT) ? ST_ADD : ST_IDLE;
        end
      end
      ST_ADD: begin
        ctl.a_step = 1'b1;
        if (sts.a_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cmd_q     <= fpce_pkg::CMD_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) cmd_q <= fpce_pkg::cmd_t'(cmd);
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* src/fpce_datapath.sv */
module fpce_datapath #(
  parameter int DEPTH    = fpce_pkg::DEPTH_DEF,
  parameter int SUM_BITS = fpce_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        cmd,
  input  logic [fpce_pkg::IDX_W-1:0]        index,
  input  logic signed [fpce_pkg::DATA_W-1:0] delta,
  input  logic [fpce_pkg::IDX_W-1:0]        size_in_use,
  input  fpce_pkg::ctl_t                    ctl,
  output fpce_pkg::sts_t                    sts,
  output logic signed [fpce_pkg::DATA_W-1:0] prefix_sum
);

  localparam int AW    = $clog2(DEPTH);
  localparam int POS_W = $clog2(DEPTH + 1);
  localparam int PW    = (POS_W > fpce_pkg::IDX_W) ? POS_W : fpce_pkg::IDX_W;

  logic [SUM_BITS-1:0] mem [DEPTH];
  logic [SUM_BITS-1:0] rdata;

  logic [PW-1:0]       qpos, apos;
  logic                a_live, rd_pend;
  logic [AW-1:0]       wr_addr, clr_cnt;
  logic [SUM_BITS-1:0] amount, acc;

  logic [PW-1:0]       live, idx, q_raw, q_start, apos_lsb, rpos, rpos_m1, qpos_cl;
  logic [PW:0]         apos_sum;
  logic                a_next_live, re, we, cmd_adds;
  logic [AW-1:0]       raddr, waddr;
  logic [SUM_BITS-1:0] wdata;

  always_comb begin
    live = (PW'(size_in_use) > PW'(DEPTH)) ? PW'(DEPTH) : PW'(size_in_use);
    idx  = PW'(index);
    // count-and-insert asks for the prefix strictly below its index
    if (fpce_pkg::cmd_t'(cmd) == fpce_pkg::CMD_COUNT)
      q_raw = (idx == '0) ? '0 : idx - PW'(1);
    else
      q_raw = idx;
    q_start  = (q_raw > live) ? live : q_raw;
    cmd_adds = (fpce_pkg::cmd_t'(cmd) == fpce_pkg::CMD_ADD) ||
               (fpce_pkg::cmd_t'(cmd) == fpce_pkg::CMD_COUNT);

    apos_lsb    = apos & (~apos + PW'(1));
    apos_sum    = {1'b0, apos} + {1'b0, apos_lsb};
    a_next_live = (apos_sum <= {1'b0, live});
    qpos_cl     = qpos & (qpos - PW'(1));

    re      = (ctl.q_step && (qpos != '0)) || (ctl.a_step && a_live);
    rpos    = ctl.q_step ? qpos : apos;
    rpos_m1 = rpos - PW'(1);
    raddr   = rpos_m1[AW-1:0];

    we    = ctl.clear || (ctl.a_step && rd_pend);
    waddr = ctl.clear ? clr_cnt : wr_addr;
    wdata = ctl.clear ? '0 : rdata + amount;

    sts.clear_last = (clr_cnt == AW'(DEPTH - 1));
    sts.q_done     = (qpos == '0) && !rd_pend;
    sts.a_done     = !a_live && !rd_pend;
  end

  // tree node i lives at address i-1
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rd_pend <= 1'b0;
      a_live  <= 1'b0;
    end else begin
      if (ctl.clear) clr_cnt <= clr_cnt + AW'(1);
      if (ctl.q_step || ctl.a_step) rd_pend <= re;
      if (ctl.load)
        a_live <= cmd_adds && (idx != '0) && (idx <= live);
      else if (ctl.a_step && a_live)
        a_live <= a_next_live;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      qpos   <= q_start;
      apos   <= idx;
      amount <= (fpce_pkg::cmd_t'(cmd) == fpce_pkg::CMD_COUNT) ? SUM_BITS'(1)
                                                               : SUM_BITS'(delta);
      acc    <= '0;
    end
    if (ctl.q_step) begin
      if (qpos != '0) qpos <= qpos_cl;
      if (rd_pend) acc <= acc + rdata;
    end
    // the write of one node overlaps the read of the next one up
    if (ctl.a_step && a_live) begin
      wr_addr <= raddr;
      apos    <= apos_sum[PW-1:0];
    end
    if (ctl.out_load) prefix_sum <= fpce_pkg::DATA_W'(acc);
  end

endmodule

/* tb/fenwick_prefix_count_engine_tb.sv */
`timescale 1ns / 100ps

module fenwick_prefix_count_engine_tb;

  localparam int DEPTH         = fpce_pkg::DEPTH_DEF;
  localparam int IDX_W         = fpce_pkg::IDX_W;
  localparam int DATA_W        = fpce_pkg::DATA_W;
  localparam int ADDR_W        = fpce_pkg::ADDR_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [ADDR_W-1:0] SIZE_ADDR =
    ADDR_W'(4 * int'(fpce_pkg::REG_SIZE_IN_USE));

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                cmd;
  logic [IDX_W-1:0]          index;
  logic signed [DATA_W-1:0]  delta;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [DATA_W-1:0]  prefix_sum;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // shadow copy of the tree and the size register
  logic [DATA_W-1:0]         tree_shadow [1:DEPTH];
  logic [IDX_W-1:0]          size_shadow;
  logic signed [DATA_W-1:0]  expected_sums [$];
  logic signed [DATA_W-1:0]  want_sum;

  bit                        idle_enabled;
  int                        rx_wait;
  int                        rx_hold;
  int                        error_count;
  int                        items_sent;
  int                        sums_checked;
  int                        size_writes;
  int                        cycle_count;

  fenwick_prefix_count_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .index      (index),
    .delta      (delta),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prefix_sum (prefix_sum),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------- tree predictor ----------------

  function automatic int unsigned live_positions();
    return (size_shadow > DEPTH) ? DEPTH : int'(size_shadow);
  endfunction

  function automatic void tree_add(int unsigned pos, logic [DATA_W-1:0] amount);
    int unsigned n;
    n = live_positions();
    if (pos == 0 || pos > n) return;
    while (pos != 0 && pos <= n) begin
      tree_shadow[pos] = tree_shadow[pos] + amount;
      pos = pos + (pos & (~pos + 1));
    end
  endfunction

  function automatic logic [DATA_W-1:0] tree_prefix(int unsigned pos);
    int unsigned n;
    logic [DATA_W-1:0] acc;
    n = live_positions();
    acc = '0;
    if (pos > n) pos = n;
    while (pos != 0) begin
      acc = acc + tree_shadow[pos];
      pos = pos & (pos - 1);
    end
    return acc;
  endfunction

  function automatic void note_sum(logic signed [DATA_W-1:0] s);
    expected_sums.insert(expected_sums.size(), s);
  endfunction

  function automatic void predict_transaction(fpce_pkg::cmd_t c, logic [IDX_W-1:0] i,
                                              logic [DATA_W-1:0] d);
    case (c)
      fpce_pkg::CMD_ADD: begin
        tree_add(i, d);
      end
      fpce_pkg::CMD_QUERY: begin
        note_sum(tree_prefix(i));
      end
      fpce_pkg::CMD_COUNT: begin
        // count of smaller ranks, then one more at this rank
        note_sum((i == 0) ? '0 : tree_prefix(i - 1));
        tree_add(i, 1);
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned n;
    int unsigned r;
    n = live_positions();
    r = $urandom_range(0, 99);
    if (r < 70 && n > 0) return IDX_W'($urandom_range(1, n));
    if (r < 78) return '0;
    if (r < 86) return IDX_W'(n);
    if (r < 92) return IDX_W'(n + 1);
    return IDX_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [DATA_W-1:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return DATA_W'(int'($urandom_range(0, 200)) - 100);
    if (r == 8) begin
      case ($urandom_range(0, 2))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return '0;
  endfunction

  function automatic fpce_pkg::cmd_t pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return fpce_pkg::CMD_ADD;
    if (r < 60) return fpce_pkg::CMD_QUERY;
    if (r < 97) return fpce_pkg::CMD_COUNT;
    return fpce_pkg::CMD_NONE;
  endfunction

  // returns in the step of the accepting edge; valid stays up for a following item
  task automatic send_item(fpce_pkg::cmd_t c, logic [IDX_W-1:0] i, logic [DATA_W-1:0] d);
    int gap;
    gap = idle_enabled ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = c;
    index    = i;
    delta    = d;
    do @(posedge clk); while (!in_ready);
    predict_transaction(c, i, d);
    items_sent++;
  endtask

  task automatic send_random_item();
    send_item(pick_cmd(), pick_index(), pick_delta());
  endtask

  // sender stops and waits for every pending sum, then lets the block finish adds
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == SIZE_ADDR) size_shadow = value[IDX_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_tree_size(logic [IDX_W-1:0] value);
    logic [DATA_W-1:0] readback;
    drain_results();
    apb_write(SIZE_ADDR, DATA_W'(value));
    size_writes++;
    apb_read(SIZE_ADDR, readback);
    if (readback !== DATA_W'(value)) begin
      $error("size_in_use mismatch: expected %0d, actual %0d", value, readback);
      error_count++;
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_empty_tree_and_extremes();
    send_item(fpce_pkg::CMD_QUERY, 11'd0,    32'h0);
    send_item(fpce_pkg::CMD_QUERY, 11'd1024, 32'hFFFF_FFFF);
    send_item(fpce_pkg::CMD_COUNT, 11'd0,    32'h0);
    send_item(fpce_pkg::CMD_ADD,   11'd1,    32'h7FFF_FFFF);
    send_item(fpce_pkg::CMD_ADD,   11'd1024, 32'h8000_0000);
    // ignored adds: empty position and beyond the size in use
    send_item(fpce_pkg::CMD_ADD,   11'd0,    32'h1234_5678);
    send_item(fpce_pkg::CMD_ADD,   11'd1025, 32'h1);
    send_item(fpce_pkg::CMD_ADD,   11'd2047, 32'h5555_5555);
    send_item(fpce_pkg::CMD_QUERY, 11'd1,    32'h0);
    send_item(fpce_pkg::CMD_QUERY, 11'd1024, 32'h0);
    send_item(fpce_pkg::CMD_QUERY, 11'd2047, 32'h0);
    send_item(fpce_pkg::CMD_COUNT, 11'd1024, 32'h0);
    send_item(fpce_pkg::CMD_COUNT, 11'd1,    32'hFFFF_FFFF);
    send_item(fpce_pkg::CMD_COUNT, 11'd2047, 32'h0);
    send_item(fpce_pkg::CMD_NONE,  11'd5,    32'hAAAA_AAAA);
    send_item(fpce_pkg::CMD_ADD,   11'd512,  32'hAAAA_AAAA);
    send_item(fpce_pkg::CMD_ADD,   11'd683,  32'h5555_5555);
    send_item(fpce_pkg::CMD_QUERY, 11'd700,  32'h0);
    send_item(fpce_pkg::CMD_QUERY, 11'd1023, 32'h0);
  endtask

  task automatic test_size_register();
    // no position in use
    set_tree_size(11'd0);
    send_item(fpce_pkg::CMD_ADD,   11'd1,    32'h5);
    send_item(fpce_pkg::CMD_QUERY, 11'd1024, 32'h0);
    send_item(fpce_pkg::CMD_COUNT, 11'd3,    32'h0);
    // above the depth acts as the depth
    set_tree_size(11'd2047);
    send_item(fpce_pkg::CMD_QUERY, 11'd2047, 32'h0);
    send_item(fpce_pkg::CMD_ADD,   11'd1024, 32'h3);
    set_tree_size(11'd1);
    send_item(fpce_pkg::CMD_COUNT, 11'd1,    32'h0);
    send_item(fpce_pkg::CMD_QUERY, 11'd1024, 32'h0);
    send_item(fpce_pkg::CMD_ADD,   11'd2,    32'h7);
    send_item(fpce_pkg::CMD_QUERY, 11'd2,    32'h0);
    set_tree_size(11'd1024);
  endtask

  task automatic test_count_smaller_runs();
    int unsigned n;
    logic [IDX_W-1:0] rank;
    for (int run = 0; run < 6; run++) begin
      n = $urandom_range(8, 64);
      set_tree_size(IDX_W'(n));
      // random ranks fed as count-and-insert, now and then a plain query in place of one
      for (int k = 0; k < 25; k++) begin
        rank = IDX_W'($urandom_range(1, n));
        if ($urandom_range(0, 7) == 0) send_item(fpce_pkg::CMD_QUERY, rank, $urandom);
        else send_item(fpce_pkg::CMD_COUNT, rank, $urandom);
      end
    end
  endtask

  task automatic test_random_mix();
    logic [IDX_W-1:0] sizes [8];
    sizes = '{11'd1024, 11'd1, 11'd2, 11'd1023, 11'd2047, 11'd0, 11'd16, 11'd513};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 8) set_tree_size(sizes[phase]);
      else set_tree_size(IDX_W'($urandom_range(1, 1024)));
      // every third phase runs without idling on either side
      idle_enabled = (phase % 3 != 2);
      for (int k = 0; k < 75; k++) send_random_item();
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_tree_size(11'd1024);
    idle_enabled = 1'b0;
    @(negedge clk);
    rx_hold = 400;
    for (int k = 0; k < 40; k++) begin
      send_item(($urandom_range(0, 1) != 0) ? fpce_pkg::CMD_QUERY : fpce_pkg::CMD_COUNT,
                pick_index(), pick_delta());
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_back_to_back();
    set_tree_size(IDX_W'($urandom_range(100, 1024)));
    idle_enabled = 1'b0;
    for (int k = 0; k < 200; k++) send_random_item();
    idle_enabled = 1'b1;
    for (int k = 0; k < 60; k++) send_random_item();
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("prefix_sum with nothing pending: actual %0d", prefix_sum);
        error_count++;
      end else begin
        want_sum = expected_sums.pop_front();
        if (prefix_sum !== want_sum) begin
          $error("prefix_sum mismatch: expected %0d, actual %0d", want_sum, prefix_sum);
          error_count++;
        end
        sums_checked++;
      end
      rx_wait = idle_enabled ? $urandom_range(0, 4) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready = 1'b0;
      rx_wait--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fenwick_prefix_count_engine_tb failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = fpce_pkg::CMD_ADD;
    index        = '0;
    delta        = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_enabled = 1'b1;
    rx_wait      = 0;
    rx_hold      = 0;
    error_count  = 0;
    items_sent   = 0;
    sums_checked = 0;
    size_writes  = 0;
    cycle_count  = 0;
    size_shadow  = fpce_pkg::SIZE_RESET;
    for (int p = 1; p <= DEPTH; p++) tree_shadow[p] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_tree_and_extremes();
    test_size_register();
    test_count_smaller_runs();
    test_random_mix();
    test_output_backpressure();
    test_back_to_back();
    drain_results();

    if (expected_sums.size() != 0) begin
      $error("%0d prefix sums never arrived", expected_sums.size());
      error_count++;
    end
    $display("adds, prefix queries and count-insert steps: %0d transactions in, %0d sums out",
             items_sent, sums_checked);
    $display("size register written %0d times, incl. zero, one, full depth and above depth",
             size_writes);
    if (error_count == 0) begin
      $display("fenwick_prefix_count_engine_tb passed");
    end else begin
      $display("fenwick_prefix_count_engine_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/fpce_pkg.sv
src/fpce_ctrl.sv
src/fpce_datapath.sv
src/fenwick_prefix_count_engine.sv
tb/fenwick_prefix_count_engine_tb.sv
